/* rtl/texel_format_decoder_top_macros.svh */
// Assertion macros shared by the texel format decoder.
`ifndef TEXEL_FORMAT_DECODER_TOP_MACROS_SVH
`define TEXEL_FORMAT_DECODER_TOP_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define TFD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define TFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tfd_pkg.sv */
// Types, codes and channel expansion functions of the texel format decoder.
package tfd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NCC_SEL = 2'd1;

  localparam logic [31:0] UNKNOWN_TEXEL = 32'hff80_8080;

  typedef enum logic [1:0] {
    KIND_DECODE = 2'd0,
    KIND_PAL_WR = 2'd1,
    KIND_NCC_WR = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    FMT_RGB332   = 4'd0,
    FMT_Y4I2Q2   = 4'd1,
    FMT_A8       = 4'd2,
    FMT_I8       = 4'd3,
    FMT_AI8      = 4'd4,
    FMT_PAL8     = 4'd5,
    FMT_APAL8    = 4'd6,
    FMT_ARGB8332 = 4'd8,
    FMT_A8Y4I2Q2 = 4'd9,
    FMT_R5G6B5   = 4'd10,
    FMT_ARGB1555 = 4'd11,
    FMT_ARGB4444 = 4'd12,
    FMT_A8I8     = 4'd13,
    FMT_APAL88   = 4'd14
  } fmt_e;

  // Stage 1 payload: raw texel plus the table words read for it.
  typedef struct packed {
    logic [15:0] raw;
    logic [23:0] pal;
    logic [31:0] ncc;
  } lk_data_t;

  // Stage 2 payload: table words plus every expanded channel any format needs.
  typedef struct packed {
    logic [15:0] raw;
    logic [23:0] pal;
    logic [31:0] ncc;
    logic [7:0]  r332;
    logic [7:0]  g332;
    logic [7:0]  b332;
    logic [7:0]  r565;
    logic [7:0]  g565;
    logic [7:0]  b555;
    logic [7:0]  r1555;
    logic [7:0]  g1555;
    logic [31:0] apal;
  } ex_data_t;

  // floor(v * 255 / 7)
  function automatic logic [7:0] widen3(input logic [2:0] v);
    logic [7:0] res;
    case (v)
      3'd0:    res = 8'd0;
      3'd1:    res = 8'd36;
      3'd2:    res = 8'd72;
      3'd3:    res = 8'd109;
      3'd4:    res = 8'd145;
      3'd5:    res = 8'd182;
      3'd6:    res = 8'd218;
      default: res = 8'd255;
    endcase
    return res;
  endfunction

  // floor(v * 255 / 31) = 8v + floor(7v / 31); the quotient uses a 265/8192 reciprocal
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [7:0]  t7;
    logic [15:0] prod;
    t7   = {v, 3'b000} - {3'b000, v};
    prod = 16'(t7) * 16'd265;
    return {v, 3'b000} + {5'd0, prod[15:13]};
  endfunction

  // floor(v * 255 / 63) = 4v + floor(v / 21)
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [1:0] q;
    if (v >= 6'd63) begin
      q = 2'd3;
    end else if (v >= 6'd42) begin
      q = 2'd2;
    end else if (v >= 6'd21) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return {v, 2'b00} + {6'd0, q};
  endfunction

endpackage

/* rtl/tfd_in_if.sv */
// Input channel of the texel format decoder: texels and table writes.
interface tfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] raw_texel;
  logic [7:0]  table_index;
  logic        table_bank;
  logic [31:0] table_value;

  modport source (
    output valid, kind, raw_texel, table_index, table_bank, table_value,
    input  ready
  );
  modport sink (
    input  valid, kind, raw_texel, table_index, table_bank, table_value,
    output ready
  );
endinterface

/* rtl/tfd_out_if.sv */
// Output channel of the texel format decoder: decoded ARGB words.
interface tfd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel_word;

  modport source (
    output valid, texel_word,
    input  ready
  );
  modport sink (
    input  valid, texel_word,
    output ready
  );
endinterface

/* rtl/tfd_lookup.sv */
// Stage 1: input transfer, palette and NCC table writes and reads.
module tfd_lookup (
  input  logic               clk_i,
  input  logic               rst_ni,
  tfd_in_if.sink             in_i,
  input  logic               ncc_sel_i,
  input  logic               en_i,
  output logic               valid_o,
  output tfd_pkg::lk_data_t  data_o
);

  logic [23:0] pal_mem [256];
  logic [31:0] ncc_mem [512];

  logic              valid_q;
  logic              en;
  logic              xfer;
  logic [23:0]       pal_rd_q;
  logic [31:0]       ncc_rd_q;
  logic [15:0]       raw_q;

  assign en         = !valid_q || en_i;
  assign in_i.ready = en;
  assign xfer       = in_i.valid && en;

  // Tables: written on transfer of a write item, read for the texel entering stage 1.
  always_ff @(posedge clk_i) begin
    if (xfer && (in_i.kind == tfd_pkg::KIND_PAL_WR)) begin
      pal_mem[in_i.table_index] <= in_i.table_value[23:0];
    end
    if (xfer && (in_i.kind == tfd_pkg::KIND_NCC_WR)) begin
      ncc_mem[{in_i.table_bank, in_i.table_index}] <= in_i.table_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pal_rd_q <= pal_mem[in_i.raw_texel[7:0]];
      ncc_rd_q <= ncc_mem[{ncc_sel_i, in_i.raw_texel[7:0]}];
      raw_q    <= in_i.raw_texel;
    end
  end

  // Only decode items travel on; table writes end here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= xfer && (in_i.kind == tfd_pkg::KIND_DECODE);
    end
  end

  assign valid_o    = valid_q;
  assign data_o.raw = raw_q;
  assign data_o.pal = pal_rd_q;
  assign data_o.ncc = ncc_rd_q;

endmodule

/* rtl/tfd_expand.sv */
// Stage 2: expand the narrow color channels to 8 bits.
module tfd_expand (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tfd_pkg::lk_data_t  data_i,
  input  logic               en_i,
  output logic               en_o,
  output logic               valid_o,
  output tfd_pkg::ex_data_t  data_o
);

  logic              valid_q;
  logic              en;
  tfd_pkg::ex_data_t data_d;
  tfd_pkg::ex_data_t data_q;
  logic [7:0]        pr;
  logic [7:0]        pg;
  logic [7:0]        pb;

  assign en   = !valid_q || en_i;
  assign en_o = en;

  assign pr = data_i.pal[23:16];
  assign pg = data_i.pal[15:8];
  assign pb = data_i.pal[7:0];

  always_comb begin
    data_d.raw   = data_i.raw;
    data_d.pal   = data_i.pal;
    data_d.ncc   = data_i.ncc;
    data_d.r332  = tfd_pkg::widen3(data_i.raw[7:5]);
    data_d.g332  = tfd_pkg::widen3(data_i.raw[4:2]);
    data_d.b332  = {4{data_i.raw[1:0]}};
    data_d.r565  = tfd_pkg::widen5(data_i.raw[15:11]);
    data_d.g565  = tfd_pkg::widen6(data_i.raw[10:5]);
    data_d.b555  = tfd_pkg::widen5(data_i.raw[4:0]);
    data_d.r1555 = tfd_pkg::widen5(data_i.raw[14:10]);
    data_d.g1555 = tfd_pkg::widen5(data_i.raw[9:5]);
    // palette entry read as packed 6:6:6:6 alpha, red, green, blue
    data_d.apal  = {pr[7:2], pr[7:6],
                    pr[1:0], pg[7:4], pr[1:0],
                    pg[3:0], pb[7:6], pg[3:2],
                    pb[5:0], pb[5:4]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/tfd_pack.sv */
// Stage 3: select the ARGB word for the format and hold it in the output register.
module tfd_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfd_pkg::fmt_e      fmt_i,
  input  logic               valid_i,
  input  tfd_pkg::ex_data_t  data_i,
  output logic               en_o,
  tfd_out_if.source          out_o
);

  logic        valid_q;
  logic        en;
  logic [31:0] word_d;
  logic [31:0] word_q;
  logic [7:0]  lo;
  logic [7:0]  hi;

  assign en   = !valid_q || out_o.ready;
  assign en_o = en;
  assign lo   = data_i.raw[7:0];
  assign hi   = data_i.raw[15:8];

  always_comb begin
    unique case (fmt_i)
      tfd_pkg::FMT_RGB332:   word_d = {8'hff, data_i.r332, data_i.g332, data_i.b332};
      tfd_pkg::FMT_Y4I2Q2:   word_d = data_i.ncc;
      tfd_pkg::FMT_A8:       word_d = {lo, lo, lo, lo};
      tfd_pkg::FMT_I8:       word_d = {8'hff, lo, lo, lo};
      tfd_pkg::FMT_AI8:      word_d = {lo[7:4], lo[7:4], {6{lo[3:0]}}};
      tfd_pkg::FMT_PAL8:     word_d = {8'hff, data_i.pal};
      tfd_pkg::FMT_APAL8:    word_d = data_i.apal;
      tfd_pkg::FMT_ARGB8332: word_d = {hi, data_i.r332, data_i.g332, data_i.b332};
      tfd_pkg::FMT_A8Y4I2Q2: word_d = {hi, data_i.ncc[23:0]};
      tfd_pkg::FMT_R5G6B5:   word_d = {8'hff, data_i.r565, data_i.g565, data_i.b555};
      tfd_pkg::FMT_ARGB1555: word_d = {{8{data_i.raw[15]}}, data_i.r1555, data_i.g1555,
                                       data_i.b555};
      tfd_pkg::FMT_ARGB4444: word_d = {data_i.raw[15:12], data_i.raw[15:12],
                                       data_i.raw[11:8],  data_i.raw[11:8],
                                       data_i.raw[7:4],   data_i.raw[7:4],
                                       data_i.raw[3:0],   data_i.raw[3:0]};
      tfd_pkg::FMT_A8I8:     word_d = {hi, lo, lo, lo};
      tfd_pkg::FMT_APAL88:   word_d = {hi, data_i.pal};
      default:               word_d = tfd_pkg::UNKNOWN_TEXEL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.texel_word = word_q;

endmodule

/* rtl/texel_format_decoder_top.sv */
// Top level of the texel format decoder: configuration registers and the three stages.
//
//   channel   dir  handshake          payload
//   in_i      in   valid / ready      kind, raw_texel, table_index, table_bank, table_value
//   out_o     out  valid / ready      texel_word
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (no read-back)
//
// One item per cycle while the output is not stalled; a texel passes the three registered stages
// in order (lookup, channel expansion, format select into the output register).
// The table read port of stage 1 is registered; table writes finish there.
// Reset clears the valid bits and configuration; table contents stay undefined.
// Each stage holds while the one after it is full and stalled; bubbles are filled.
`include "texel_format_decoder_top_macros.svh"

module texel_format_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tfd_in_if.sink                         in_i,
  tfd_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tfd_pkg::fmt_e     fmt_q;
  logic              ncc_sel_q;
  logic              lk_valid;
  tfd_pkg::lk_data_t lk_data;
  logic              ex_valid;
  tfd_pkg::ex_data_t ex_data;
  logic              ex_en;
  logic              pk_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= tfd_pkg::FMT_RGB332;
      ncc_sel_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfd_pkg::CFG_FORMAT:  fmt_q     <= tfd_pkg::fmt_e'(cfg_data_i[3:0]);
        tfd_pkg::CFG_NCC_SEL: ncc_sel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tfd_lookup u_lookup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .ncc_sel_i (ncc_sel_q),
    .en_i      (ex_en),
    .valid_o   (lk_valid),
    .data_o    (lk_data)
  );

  tfd_expand u_expand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lk_valid),
    .data_i  (lk_data),
    .en_i    (pk_en),
    .en_o    (ex_en),
    .valid_o (ex_valid),
    .data_o  (ex_data)
  );

  tfd_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fmt_i   (fmt_q),
    .valid_i (ex_valid),
    .data_i  (ex_data),
    .en_o    (pk_en),
    .out_o   (out_o)
  );

  `TFD_ASSERT_NEXT(a_write_no_result, clk_i, rst_ni, in_i.valid && in_i.ready && (in_i.kind != tfd_pkg::KIND_DECODE), !lk_valid, "table write entered the result pipeline")
  `TFD_ASSERT_NEXT(a_decode_enters, clk_i, rst_ni, in_i.valid && in_i.ready && (in_i.kind == tfd_pkg::KIND_DECODE), lk_valid, "decode transfer lost at stage 1")
  `TFD_ASSERT_IMPLY(a_blocked_only_full, clk_i, rst_ni, !in_i.ready, lk_valid && ex_valid && out_o.valid, "input blocked with a free stage")
  `TFD_ASSERT_NEXT(a_stage2_hold, clk_i, rst_ni, ex_valid && !pk_en, ex_valid && $stable(ex_data), "stage 2 item changed while stalled")

endmodule
